// File: hdl/ps2_mouse_host_init_and_decode_assert.svh
// Assertion helpers for the PS/2 mouse host.
`ifndef PS2_MOUSE_HOST_INIT_AND_DECODE_ASSERT_SVH
`define PS2_MOUSE_HOST_INIT_AND_DECODE_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define PMH_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("ps2 mouse host: same-cycle check failed");

// Check a consequence in the cycle after its condition.
`define PMH_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("ps2 mouse host: next-cycle check failed");

`endif

// File: hdl/ps2mh_pkg.sv
package ps2mh_pkg;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    localparam logic [7:0] ACK_BYTE   = 8'hFA;
    localparam logic [7:0] ID_WHEEL   = 8'h03;
    localparam logic [7:0] TAP_CLEAR  = 8'h08;

    localparam logic [4:0] STEP_BASIC1_END = 5'd2;
    localparam logic [4:0] STEP_BASIC2_END = 5'd5;
    localparam logic [4:0] STEP_KNOCK_END  = 5'd11;
    localparam logic [4:0] STEP_SEND_ID    = 5'd12;
    localparam logic [4:0] STEP_WAIT_ID    = 5'd13;
    localparam logic [4:0] STEP_FINAL      = 5'd14;
    localparam logic [4:0] STEP_LAST       = 5'd19;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        tx_byte;
        logic [2:0]        buttons;
        logic signed [9:0] delta_x;
        logic signed [9:0] delta_y;
        logic signed [1:0] wheel_x;
        logic signed [1:0] wheel_y;
        logic              detected_mode;
    } result_t;

    // Command byte sent at each step of the autodetect sequence.
    function automatic logic [7:0] init_tx_byte(input logic [4:0] step);
        logic [7:0] b;
        begin
            unique case (step)
                5'd0, 5'd3, 5'd15:            b = 8'hF4;
                5'd1, 5'd4, 5'd6, 5'd8, 5'd10, 5'd16:
                                              b = 8'hF3;
                5'd2, 5'd5, 5'd9, 5'd17:      b = 8'd100;
                5'd7:                         b = 8'd200;
                5'd11:                        b = 8'd80;
                5'd12:                        b = 8'hF2;
                5'd14:                        b = 8'hE6;
                5'd18:                        b = 8'hE8;
                5'd19:                        b = 8'h03;
                default:                      b = 8'h00;
            endcase
            init_tx_byte = b;
        end
    endfunction

endpackage

// File: hdl/ps2_mouse_host_init_and_decode.sv
// PS/2 mouse host: a start transaction (tuser = 1) runs the autodetect
// sequence, giving one command byte to send per transaction and expecting
// each mouse reply as the next receive transaction; the sequence ends with
// an init-done or init-failed result and selects 3-byte or 4-byte wheel
// packets from the ID byte. Outside of initialization, received bytes are
// framed into packets (first byte must have bits 7:6 clear) and each full
// packet yields one movement result. Bytes that only fill a packet, bytes
// dropped by the sync check, or a send-ID acknowledge, produce no result.
// The block takes one transaction per clock while the result side is not
// stalled; each passes through the input register, then one pass of decode
// and sequencing logic into the result register. The result register is
// followed by the output handshake; new transactions keep flowing while a
// result is delivered if the downstream side accepts one result per cycle.
module ps2_mouse_host_init_and_decode
    import ps2mh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // tap button value register
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    // receive side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] command
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] tx_byte, [10:8] buttons, [20:11] delta_x,
                                   // [30:21] delta_y, [32:31] wheel_x,
                                   // [34:33] wheel_y, [35] detected_mode, [39:36] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam logic PH_DECODE = 1'b0;
    localparam logic PH_INIT   = 1'b1;

    // configuration
    logic [2:0] tap_cfg_reg;

    // input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // block state
    logic       phase_reg,    phase_next;
    logic [4:0] step_reg,     step_next;
    logic       gerr_reg,     gerr_next;
    logic       wheel_reg,    wheel_next;
    logic [2:0] tap_held_reg, tap_held_next;
    logic [1:0] pos_reg,      pos_next;
    logic [7:0] store_reg [3];
    logic       store_we;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res_next;
    logic       res_valid;

    logic       advance;

    // Move the input register into the result stage when the result
    // register is free or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Signed movement value; a zero byte stays zero in 3-byte mode.
    function automatic logic signed [9:0] move_val(input logic [7:0] b, input logic neg,
                                                   input logic quirk);
        logic signed [9:0] v;
        begin
            if (quirk && b == 8'h00)
                v = 10'sd0;
            else if (neg)
                v = {2'b11, b};
            else
                v = {2'b00, b};
            move_val = v;
        end
    endfunction

    always_comb
    begin
        logic [7:0]        rx;
        logic              ack;
        logic              fail;
        logic              last;
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [7:0]        b2;
        logic [7:0]        b3;
        logic              quirk;
        logic signed [9:0] mx;
        logic signed [9:0] my;

        rx    = in_byte_reg;
        ack   = (rx == ACK_BYTE);
        fail  = 1'b0;
        last  = 1'b0;
        quirk = !wheel_reg;
        b0    = store_reg[0];
        b1    = store_reg[1];
        b2    = wheel_reg ? store_reg[2] : rx;
        b3    = rx;
        mx    = 10'sd0;
        my    = 10'sd0;

        phase_next    = phase_reg;
        step_next     = step_reg;
        gerr_next     = gerr_reg;
        wheel_next    = wheel_reg;
        tap_held_next = tap_held_reg;
        pos_next      = pos_reg;
        store_we      = 1'b0;
        res_valid     = 1'b0;
        res_next      = '0;

        if (in_cmd_reg)
        begin
            // restart the sequence from its first byte
            phase_next       = PH_INIT;
            step_next        = 5'd0;
            gerr_next        = 1'b0;
            wheel_next       = 1'b0;
            pos_next         = 2'd0;
            res_valid        = 1'b1;
            res_next.kind    = KIND_TX;
            res_next.tx_byte = init_tx_byte(5'd0);
        end
        else if (phase_reg == PH_INIT)
        begin
            if (step_reg < STEP_SEND_ID)
            begin
                gerr_next = gerr_reg | !ack;
                if (step_reg == STEP_BASIC1_END || step_reg == STEP_BASIC2_END ||
                    step_reg == STEP_KNOCK_END)
                begin
                    // first basic group never fails
                    fail      = (step_reg != STEP_BASIC1_END) && gerr_next;
                    gerr_next = 1'b0;
                end
                res_valid = 1'b1;
                if (fail)
                begin
                    phase_next    = PH_DECODE;
                    step_next     = 5'd0;
                    wheel_next    = 1'b0;
                    pos_next      = 2'd0;
                    res_next.kind = KIND_FAIL;
                end
                else
                begin
                    step_next        = step_reg + 5'd1;
                    res_next.kind    = KIND_TX;
                    res_next.tx_byte = init_tx_byte(step_reg + 5'd1);
                end
            end
            else if (step_reg == STEP_SEND_ID)
            begin
                if (ack)
                begin
                    // hold for the ID byte, nothing to send yet
                    step_next = STEP_WAIT_ID;
                end
                else
                begin
                    wheel_next       = 1'b0;
                    step_next        = STEP_FINAL;
                    res_valid        = 1'b1;
                    res_next.kind    = KIND_TX;
                    res_next.tx_byte = init_tx_byte(STEP_FINAL);
                end
            end
            else if (step_reg == STEP_WAIT_ID)
            begin
                wheel_next       = (rx == ID_WHEEL);
                step_next        = STEP_FINAL;
                res_valid        = 1'b1;
                res_next.kind    = KIND_TX;
                res_next.tx_byte = init_tx_byte(STEP_FINAL);
            end
            else if (step_reg >= STEP_LAST)
            begin
                phase_next    = PH_DECODE;
                step_next     = 5'd0;
                pos_next      = 2'd0;
                res_valid     = 1'b1;
                res_next.kind = KIND_DONE;
            end
            else
            begin
                step_next        = step_reg + 5'd1;
                res_valid        = 1'b1;
                res_next.kind    = KIND_TX;
                res_next.tx_byte = init_tx_byte(step_reg + 5'd1);
            end
        end
        else if (!(pos_reg == 2'd0 && rx[7:6] != 2'b00))
        begin
            last = wheel_reg ? (pos_reg == 2'd3) : (pos_reg == 2'd2);
            if (!last)
            begin
                store_we = 1'b1;
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                pos_next         = 2'd0;
                res_valid        = 1'b1;
                res_next.kind    = KIND_MOVE;
                res_next.buttons = {b0[0], b0[2:1]};
                if (b0 == 8'h00 && tap_cfg_reg != 3'd0)
                begin
                    tap_held_next    = tap_cfg_reg;
                    res_next.buttons = tap_cfg_reg;
                end
                else if (tap_held_reg != 3'd0)
                begin
                    if (b0 == TAP_CLEAR)
                        tap_held_next = 3'd0;
                    res_next.buttons = tap_held_next;
                end
                mx               = move_val(b1, b0[4], quirk);
                my               = move_val(b2, b0[5], quirk);
                res_next.delta_x = mx;
                res_next.delta_y = -my;
                if (!quirk)
                begin
                    case (b3[3:0])
                        4'hF:    res_next.wheel_y = 2'sd1;
                        4'h1:    res_next.wheel_y = -2'sd1;
                        4'hE:    res_next.wheel_x = 2'sd1;
                        4'h2:    res_next.wheel_x = -2'sd1;
                        default: ;
                    endcase
                end
            end
        end
        res_next.detected_mode = wheel_next;
    end

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_cfg_reg <= 3'd0;
        else if (cfg_we)
            tap_cfg_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // block state, advanced once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DECODE;
            step_reg     <= 5'd0;
            gerr_reg     <= 1'b0;
            wheel_reg    <= 1'b0;
            tap_held_reg <= 3'd0;
            pos_reg      <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            gerr_reg     <= gerr_next;
            wheel_reg    <= wheel_next;
            tap_held_reg <= tap_held_next;
            pos_reg      <= pos_next;
        end
    end

    // packet bytes, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance && store_we)
            store_reg[pos_reg] <= in_byte_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'b0000, out_reg.detected_mode, out_reg.wheel_y, out_reg.wheel_x,
                       out_reg.delta_y, out_reg.delta_x, out_reg.buttons, out_reg.tx_byte};

`include "ps2_mouse_host_init_and_decode_assert.svh"

    // sequencer never runs past the last step
    `PMH_ASSERT_SAME(a_step_range, 1'b1, step_reg <= STEP_LAST)
    // decoding phase keeps the sequencer parked at its first step
    `PMH_ASSERT_SAME(a_decode_step_zero, phase_reg == PH_DECODE, step_reg == 5'd0)
    // 3-byte framing never reaches the fourth byte slot
    `PMH_ASSERT_SAME(a_pos_range, !wheel_reg, pos_reg != 2'd3)
    // only movement results carry movement fields
    `PMH_ASSERT_NEXT(a_nonmove_zero, advance && res_valid && res_next.kind != KIND_MOVE,
                     m_tdata[34:8] == 27'd0)

endmodule

// File: tb/mouse_board_pkg.sv
`timescale 1ns / 1ps

package mouse_board_pkg;
    import ps2mh_pkg::*;

    // Low nibble of the fourth packet byte that gives a wheel step.
    localparam logic [3:0] NIB_UP    = 4'hF;
    localparam logic [3:0] NIB_DOWN  = 4'h1;
    localparam logic [3:0] NIB_RIGHT = 4'hE;
    localparam logic [3:0] NIB_LEFT  = 4'h2;

    class mouse_result_board;
        logic [2:0] tap_button;
        bit         in_init;
        logic [4:0] init_step;
        bit         group_error;
        bit         wheel_mode;
        logic [2:0] tap_held;
        logic [7:0] packet_bytes [0:2];
        int         byte_pos;
        logic [7:0] command_seq [0:19];
        result_t    pending_results [$];
        int         errors;

        function new();
            command_seq = '{8'hF4, 8'hF3, 8'd100,
                            8'hF4, 8'hF3, 8'd100,
                            8'hF3, 8'd200, 8'hF3, 8'd100, 8'hF3, 8'd80,
                            8'hF2, 8'h00,
                            8'hE6, 8'hF4, 8'hF3, 8'd100, 8'hE8, 8'h03};
            tap_button   = '0;
            in_init      = 0;
            init_step    = '0;
            group_error  = 0;
            wheel_mode   = 0;
            tap_held     = '0;
            packet_bytes = '{8'h00, 8'h00, 8'h00};
            byte_pos     = 0;
            errors       = 0;
        endfunction

        function void set_tap(input logic [2:0] value);
            tap_button = value;
        endfunction

        function result_t plain_result(input logic [1:0] kind, input logic [7:0] tx);
            result_t r;
            r = '0;
            r.kind = kind;
            r.tx_byte = tx;
            r.detected_mode = wheel_mode;
            return r;
        endfunction

        function logic signed [9:0] movement(input logic [7:0] b, input logic neg,
                                             input bit quirk);
            if (quirk && b == 8'h00)
                return '0;
            return neg ? {2'b11, b} : {2'b00, b};
        endfunction

        function void decode_packet(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3);
            result_t    r;
            logic [2:0] btn;
            bit         quirk;
            quirk = !wheel_mode;
            btn = {b0[0], b0[2], b0[1]};
            if (b0 == 8'h00 && tap_button != 3'd0) begin
                tap_held = tap_button;
                btn = tap_held;
            end
            else if (tap_held != 3'd0) begin
                if (b0 == TAP_CLEAR)
                    tap_held = '0;
                btn = tap_held;
            end
            r = plain_result(KIND_MOVE, 8'h00);
            r.buttons = btn;
            r.delta_x = movement(b1, b0[4], quirk);
            r.delta_y = -movement(b2, b0[5], quirk);
            if (!quirk) begin
                case (b3[3:0])
                    NIB_UP:    r.wheel_y = 2'sd1;
                    NIB_DOWN:  r.wheel_y = -2'sd1;
                    NIB_RIGHT: r.wheel_x = 2'sd1;
                    NIB_LEFT:  r.wheel_x = -2'sd1;
                    default:   ;
                endcase
            end
            pending_results.push_back(r);
        endfunction

        function void advance_init(input logic [7:0] rx);
            logic [4:0] s;
            bit         ack;
            bit         fail;
            s = init_step;
            ack = (rx == ACK_BYTE);
            if (s < STEP_SEND_ID) begin
                if (!ack)
                    group_error = 1;
                if (s == STEP_BASIC1_END || s == STEP_BASIC2_END || s == STEP_KNOCK_END) begin
                    fail = (s != STEP_BASIC1_END) && group_error;
                    group_error = 0;
                    if (fail) begin
                        in_init = 0;
                        init_step = '0;
                        wheel_mode = 0;
                        byte_pos = 0;
                        pending_results.push_back(plain_result(KIND_FAIL, 8'h00));
                        return;
                    end
                end
                init_step = s + 5'd1;
                pending_results.push_back(plain_result(KIND_TX, command_seq[init_step]));
            end
            else if (s == STEP_SEND_ID) begin
                if (ack) begin
                    init_step = STEP_WAIT_ID;
                    return;
                end
                wheel_mode = 0;
                init_step = STEP_FINAL;
                pending_results.push_back(plain_result(KIND_TX, command_seq[STEP_FINAL]));
            end
            else if (s == STEP_WAIT_ID) begin
                wheel_mode = (rx == ID_WHEEL);
                init_step = STEP_FINAL;
                pending_results.push_back(plain_result(KIND_TX, command_seq[STEP_FINAL]));
            end
            else if (s >= STEP_LAST) begin
                in_init = 0;
                init_step = '0;
                byte_pos = 0;
                pending_results.push_back(plain_result(KIND_DONE, 8'h00));
            end
            else begin
                init_step = s + 5'd1;
                pending_results.push_back(plain_result(KIND_TX, command_seq[init_step]));
            end
        endfunction

        // Returns 0 when the byte is dropped by the sync check.
        function bit note_accepted(input bit cmd, input logic [7:0] rx);
            int len;
            if (cmd) begin
                in_init = 1;
                init_step = '0;
                group_error = 0;
                wheel_mode = 0;
                byte_pos = 0;
                pending_results.push_back(plain_result(KIND_TX, command_seq[0]));
                return 1;
            end
            if (in_init) begin
                advance_init(rx);
                return 1;
            end
            if (byte_pos == 0 && rx[7:6] != 2'b00)
                return 0;
            len = wheel_mode ? 4 : 3;
            if (byte_pos + 1 < len) begin
                packet_bytes[byte_pos] = rx;
                byte_pos++;
                return 1;
            end
            byte_pos = 0;
            if (len == 3)
                decode_packet(packet_bytes[0], packet_bytes[1], rx, 8'h00);
            else
                decode_packet(packet_bytes[0], packet_bytes[1], packet_bytes[2], rx);
            return 1;
        endfunction

        function void check_field(input string name, input int expv, input int actv);
            if (expv != actv) begin
                $error("%s: expected %0d, actual %0d", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_result(input logic [1:0] kind, input logic [39:0] data);
            result_t e;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d tdata %h", kind, data);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            check_field("kind", e.kind, kind);
            check_field("tx_byte", e.tx_byte, data[7:0]);
            check_field("buttons", e.buttons, data[10:8]);
            check_field("delta_x", $signed(e.delta_x), $signed(data[20:11]));
            check_field("delta_y", $signed(e.delta_y), $signed(data[30:21]));
            check_field("wheel_x", $signed(e.wheel_x), $signed(data[32:31]));
            check_field("wheel_y", $signed(e.wheel_y), $signed(data[34:33]));
            check_field("detected_mode", e.detected_mode, data[35]);
            check_field("tdata padding", 0, data[39:36]);
        endfunction
    endclass

endpackage

// File: tb/ps2_mouse_host_init_and_decode_test.sv
`timescale 1ns / 1ps

module ps2_mouse_host_init_and_decode_test;
    import ps2mh_pkg::*;
    import mouse_board_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SEGMENTS     = 6;
    localparam int SEGMENT_GOAL = 192;   // counted byte transactions per segment
    localparam int SETTLE       = 8;     // settle cycles after the predicted results drain

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_wdata = 3'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    mouse_result_board board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_quiet    = 0;
    int recv_quiet    = 0;
    int counted_items = 0;
    int cycle_count   = 0;

    ps2_mouse_host_init_and_decode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ps2_mouse_host_init_and_decode test failed");
            $finish;
        end
    end

    // Stall the result side at random; now and then hold tready high for a
    // stretch so that back-to-back results also occur.
    always @(negedge clk)
    begin
        if (recv_quiet > 0)
        begin
            recv_quiet--;
            m_tready <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 99) < 3)
                recv_quiet = $urandom_range(10, 60);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata);
    end

    // Offer one transaction: idle first at random, then hold tvalid until
    // the block takes it, and hand the accepted item to the predictor.
    task automatic send_item(input bit cmd, input logic [7:0] rx);
        @(negedge clk);
        while (send_quiet == 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        if (send_quiet > 0)
            send_quiet--;
        else if ($urandom_range(0, 99) < 2)
            send_quiet = $urandom_range(10, 40);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= rx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (board.note_accepted(cmd, rx))
            counted_items++;
    endtask

    // Drop tvalid, let every predicted result drain, then allow for bytes
    // still in flight that give no result.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tap(input logic [2:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_tap(value);
    endtask

    // Run the autodetect sequence, replying to each command byte. Mostly
    // acknowledge; inject bad replies at err_pct and restart now and then.
    task automatic send_init(input int err_pct, input int wheel_pct);
        int         guard;
        logic [7:0] reply;
        guard = 0;
        send_item(1'b1, 8'($urandom));
        while (board.in_init && guard < 40)
        begin
            guard++;
            if ($urandom_range(0, 99) < 2)
            begin
                send_item(1'b1, 8'($urandom));
            end
            else
            begin
                if (board.init_step == STEP_WAIT_ID)
                    reply = ($urandom_range(0, 99) < wheel_pct) ? ID_WHEEL : 8'($urandom);
                else if (board.init_step == STEP_SEND_ID)
                    reply = ($urandom_range(0, 99) < 85) ? ACK_BYTE : 8'($urandom);
                else
                    reply = ($urandom_range(0, 99) < err_pct) ? 8'($urandom) : ACK_BYTE;
                send_item(1'b0, reply);
            end
        end
    endtask

    function automatic logic [7:0] move_byte();
        return ($urandom_range(0, 99) < 20) ? 8'h00 : 8'($urandom);
    endfunction

    // Send one packet framed for the current packet length.
    task automatic send_packet();
        logic [7:0] head;
        logic [3:0] nib;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            head = 8'h00;
        else if (pick < 18)
            head = TAP_CLEAR;
        else
            head = {2'b00, 6'($urandom)};
        send_item(1'b0, head);
        send_item(1'b0, move_byte());
        send_item(1'b0, move_byte());
        if (board.wheel_mode && !board.in_init)
        begin
            case ($urandom_range(0, 4))
                0:       nib = NIB_UP;
                1:       nib = NIB_DOWN;
                2:       nib = NIB_RIGHT;
                3:       nib = NIB_LEFT;
                default: nib = 4'($urandom);
            endcase
            send_item(1'b0, {4'($urandom), nib});
        end
    endtask

    // Noise: a lone start, a random byte, or a cut-off packet.
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            send_item(1'b1, 8'($urandom));
        else if (pick < 65)
            send_item(1'b0, 8'($urandom));
        else
        begin
            send_item(1'b0, {2'b00, 6'($urandom)});
            send_item(1'b0, 8'($urandom));
        end
    endtask

    initial
    begin
        logic [2:0] tap_values [0:SEGMENTS-1];
        int         roll;
        int         goal;
        tap_values = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd1, 3'd5};

        // Hold reset, then release it at a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        goal = 0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // Sender light and receiver heavy idling, then swapped, then none.
            if (seg < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 88;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_tap(tap_values[seg]);

            if (seg == 0)
            begin
                // Full autodetect with all replies acknowledged and wheel ID.
                send_item(1'b1, 8'h00);
                for (int i = 0; i < 13; i++)
                    send_item(1'b0, ACK_BYTE);
                send_item(1'b0, ID_WHEEL);
                for (int i = 0; i < 6; i++)
                    send_item(1'b0, ACK_BYTE);
                // Out-of-sync first byte, then a tap packet with full dx.
                send_item(1'b0, 8'hC0);
                send_item(1'b0, 8'h00);
                send_item(1'b0, 8'hFF);
                send_item(1'b0, 8'h00);
                send_item(1'b0, {4'h0, NIB_UP});
            end

            goal += SEGMENT_GOAL;
            while (counted_items < goal)
            begin
                roll = $urandom_range(0, 99);
                if (!board.in_init && roll < 10)
                    send_init(($urandom_range(0, 99) < 70) ? 0 : 8, 60);
                else if (roll < 88)
                    send_packet();
                else
                    send_noise();
            end
        end

        // Wait for the last results, then for any stray ones.
        drain_results();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("ps2_mouse_host_init_and_decode test passed");
        else
            $display("ps2_mouse_host_init_and_decode test failed");
        $finish;
    end

endmodule
